// ----- hw/rtl/cdc_pkg.sv -----
package cdc_pkg;

   // operation codes
   localparam logic OP_DAYS_TO_DATE = 1'b0;
   localparam logic OP_DATE_TO_DAYS = 1'b1;

   // register stages in each conversion path
   localparam int PATH_STAGES = 7;

   // one converted date as it leaves a conversion path
   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic signed [24:0] day_number;
      logic               leap;
      logic               out_of_range;
   } cdc_date_type;

   // days from march 1 to the first of each month, march-based month index
   function automatic logic [8:0] cum_days(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ----- hw/rtl/cdc_d2c.sv -----
module cdc_d2c (
   input  logic                  clock,
   input  logic signed [24:0]    day_number,
   output cdc_pkg::cdc_date_type date
);
   import cdc_pkg::*;

   // 4 * (days + march-based offset of 200 eras before year 0) + 3
   localparam logic signed [28:0] N1_BIAS    = 29'sd119755475;
   // ceil(2^46 / 146097), exact for 28-bit counts
   localparam logic [28:0]        CENT_RECIP = 29'd481657695;
   localparam logic [17:0]        ERA_DAYS   = 18'd146097;
   // ceil(2^32 / 1461)
   localparam logic [21:0]        YEAR_RECIP = 22'd2939745;
   localparam logic [10:0]        QUAD_DAYS  = 11'd1461;
   localparam logic [11:0]        MON_MUL    = 12'd2141;
   localparam logic [19:0]        MON_ADD    = 20'd197913;
   localparam logic signed [18:0] YEAR_BIAS  = 19'sd80000;

   // stage 1: biased and scaled day count
   logic signed [28:0] n1_wide;
   logic [27:0]        n1_in;
   logic [27:0]        n1_1_ff;
   logic signed [24:0] dn1_ff;

   assign n1_wide = (29'(day_number) <<< 2) + N1_BIAS;
   assign n1_in   = n1_wide[27:0];

   always_ff @(posedge clock) begin
      n1_1_ff <= n1_in;
      dn1_ff  <= day_number;
   end

   // stage 2: century count by reciprocal multiply
   logic [56:0]        cent_prod;
   logic [10:0]        cent_in;
   logic [10:0]        cent2_ff;
   logic [27:0]        n1_2_ff;
   logic signed [24:0] dn2_ff;

   assign cent_prod = n1_1_ff * CENT_RECIP;
   assign cent_in   = cent_prod[56:46];

   always_ff @(posedge clock) begin
      cent2_ff <= cent_in;
      n1_2_ff  <= n1_1_ff;
      dn2_ff   <= dn1_ff;
   end

   // stage 3: day within the century
   logic [27:0]        cent_days;
   logic [27:0]        cent_rem;
   logic [15:0]        nc_in;
   logic [15:0]        nc3_ff;
   logic [10:0]        cent3_ff;
   logic signed [24:0] dn3_ff;

   assign cent_days = cent2_ff * ERA_DAYS;
   assign cent_rem  = n1_2_ff - cent_days;
   assign nc_in     = cent_rem[17:2];

   always_ff @(posedge clock) begin
      nc3_ff   <= nc_in;
      cent3_ff <= cent2_ff;
      dn3_ff   <= dn2_ff;
   end

   // stage 4: year within the century
   logic [17:0]        n2_in;
   logic [39:0]        yr_prod;
   logic [6:0]         z_in;
   logic [6:0]         z4_ff;
   logic [17:0]        n2_4_ff;
   logic [10:0]        cent4_ff;
   logic signed [24:0] dn4_ff;

   assign n2_in   = {nc3_ff, 2'b11};
   assign yr_prod = n2_in * YEAR_RECIP;
   assign z_in    = yr_prod[38:32];

   always_ff @(posedge clock) begin
      z4_ff    <= z_in;
      n2_4_ff  <= n2_in;
      cent4_ff <= cent3_ff;
      dn4_ff   <= dn3_ff;
   end

   // stage 5: day of the march-based year, base year, leap flag
   logic [17:0]        z_days;
   logic [17:0]        z_rem;
   logic [8:0]         ny_in;
   logic [16:0]        ybase_in;
   logic               leap_in;
   logic [8:0]         ny5_ff;
   logic [16:0]        ybase5_ff;
   logic               leap5_ff;
   logic signed [24:0] dn5_ff;

   assign z_days   = z4_ff * QUAD_DAYS;
   assign z_rem    = n2_4_ff - z_days;
   assign ny_in    = z_rem[10:2];
   assign ybase_in = cent4_ff * 7'd100 + 17'(z4_ff);
   // the year ending in this february has 366 days
   assign leap_in  = (z4_ff[1:0] == 2'd3) && ((z4_ff != 7'd99) || (cent4_ff[1:0] == 2'd3));

   always_ff @(posedge clock) begin
      ny5_ff    <= ny_in;
      ybase5_ff <= ybase_in;
      leap5_ff  <= leap_in;
      dn5_ff    <= dn4_ff;
   end

   // stage 6: march-based month, 3 to 14
   logic [19:0]        mon_prod;
   logic [3:0]         m_in;
   logic [3:0]         m6_ff;
   logic [8:0]         ny6_ff;
   logic [16:0]        ybase6_ff;
   logic               leap6_ff;
   logic signed [24:0] dn6_ff;

   assign mon_prod = ny5_ff * MON_MUL + MON_ADD;
   assign m_in     = mon_prod[19:16];

   always_ff @(posedge clock) begin
      m6_ff     <= m_in;
      ny6_ff    <= ny5_ff;
      ybase6_ff <= ybase5_ff;
      leap6_ff  <= leap5_ff;
      dn6_ff    <= dn5_ff;
   end

   // stage 7: civil month, day and year, range check
   logic               jan_feb;
   logic [3:0]         mon;
   logic [3:0]         mp;
   logic [8:0]         day_sum;
   logic signed [18:0] year_wide;
   logic               oor;
   cdc_date_type       date_in;
   cdc_date_type       date_ff;

   assign jan_feb   = m6_ff > 4'd12;
   assign mon       = jan_feb ? m6_ff - 4'd12 : m6_ff;
   assign mp        = m6_ff - 4'd3;
   assign day_sum   = ny6_ff - cum_days(mp) + 9'd1;
   assign year_wide = $signed({2'b00, ybase6_ff}) + $signed({18'd0, jan_feb}) - YEAR_BIAS;
   assign oor       = (year_wide < -19'sd32768) || (year_wide > 19'sd32767);

   always_comb begin
      date_in.year         = oor ? 16'sd0 : year_wide[15:0];
      date_in.month        = oor ? 4'd0 : mon;
      date_in.day          = oor ? 5'd0 : day_sum[4:0];
      date_in.day_number   = dn6_ff;
      date_in.leap         = leap6_ff;
      date_in.out_of_range = oor;
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
   end

   assign date = date_ff;

endmodule

// ----- hw/rtl/cdc_c2d.sv -----
module cdc_c2d (
   input  logic                  clock,
   input  logic signed [15:0]    year,
   input  logic [3:0]            month,
   input  logic [4:0]            day,
   output cdc_pkg::cdc_date_type date
);
   import cdc_pkg::*;

   // 100 eras, keeps the shifted year positive
   localparam logic signed [17:0] UU_BIAS    = 18'sd40000;
   // ceil(2^24 / 100), exact for 17-bit years
   localparam logic [17:0]        HUND_RECIP = 18'd167773;
   localparam logic [17:0]        ERA_DAYS   = 18'd146097;
   // epoch shift plus the 100 added eras
   localparam logic signed [26:0] DN_BIAS    = 27'sd15329168;

   // stage 1: clamp month, shift year to a march-based positive year
   logic [3:0]         mc_in;
   logic               early;
   logic signed [17:0] uu_wide;
   logic [16:0]        uu1_ff;
   logic [3:0]         mc1_ff;
   logic [4:0]         day1_ff;
   logic signed [15:0] year1_ff;

   assign mc_in   = (month == 4'd0) ? 4'd1 : ((month > 4'd12) ? 4'd12 : month);
   assign early   = mc_in <= 4'd2;
   assign uu_wide = 18'(year) + UU_BIAS - $signed({17'd0, early});

   always_ff @(posedge clock) begin
      uu1_ff   <= uu_wide[16:0];
      mc1_ff   <= mc_in;
      day1_ff  <= day;
      year1_ff <= year;
   end

   // stage 2: century count by reciprocal multiply
   logic [34:0]        c_prod;
   logic [9:0]         c2_ff;
   logic [16:0]        uu2_ff;
   logic [3:0]         mc2_ff;
   logic [4:0]         day2_ff;
   logic signed [15:0] year2_ff;

   assign c_prod = uu1_ff * HUND_RECIP;

   always_ff @(posedge clock) begin
      c2_ff    <= c_prod[33:24];
      uu2_ff   <= uu1_ff;
      mc2_ff   <= mc1_ff;
      day2_ff  <= day1_ff;
      year2_ff <= year1_ff;
   end

   // stage 3: year within the century, day of the march-based year
   logic [16:0]        c_hund;
   logic [16:0]        r_diff;
   logic [3:0]         mp;
   logic signed [9:0]  doy_in;
   logic [6:0]         r3_ff;
   logic [9:0]         c3_ff;
   logic signed [9:0]  doy3_ff;
   logic [3:0]         mc3_ff;
   logic [4:0]         day3_ff;
   logic signed [15:0] year3_ff;

   assign c_hund = c2_ff * 7'd100;
   assign r_diff = uu2_ff - c_hund;
   assign mp     = (mc2_ff > 4'd2) ? mc2_ff - 4'd3 : mc2_ff + 4'd9;
   // day zero runs back into the previous month
   assign doy_in = $signed({1'b0, cum_days(mp)}) + $signed({5'd0, day2_ff}) - 10'sd1;

   always_ff @(posedge clock) begin
      r3_ff    <= r_diff[6:0];
      c3_ff    <= c2_ff;
      doy3_ff  <= doy_in;
      mc3_ff   <= mc2_ff;
      day3_ff  <= day2_ff;
      year3_ff <= year2_ff;
   end

   // stage 4: year of era, leap-day corrections, leap flag
   logic [8:0]          yoe_in;
   logic [6:0]          corr;
   logic signed [10:0]  extra_in;
   logic                leap_in;
   logic [8:0]          yoe4_ff;
   logic signed [10:0]  extra4_ff;
   logic [7:0]          era4_ff;
   logic                leap4_ff;
   logic [3:0]          mc4_ff;
   logic [4:0]          day4_ff;
   logic signed [15:0]  year4_ff;

   assign yoe_in   = 9'(c3_ff[1:0]) * 9'd100 + 9'(r3_ff);
   assign corr     = 7'(c3_ff[1:0]) * 7'd24 + 7'(r3_ff[6:2]);
   assign extra_in = $signed({4'd0, corr}) + 11'(doy3_ff);
   // only looked at for february, when the shifted year ends in that february
   assign leap_in  = (r3_ff[1:0] == 2'd3) && ((r3_ff != 7'd99) || (c3_ff[1:0] == 2'd3));

   always_ff @(posedge clock) begin
      yoe4_ff   <= yoe_in;
      extra4_ff <= extra_in;
      era4_ff   <= c3_ff[9:2];
      leap4_ff  <= leap_in;
      mc4_ff    <= mc3_ff;
      day4_ff   <= day3_ff;
      year4_ff  <= year3_ff;
   end

   // stage 5: day of era
   logic [17:0]        yoe_days;
   logic signed [18:0] doe_in;
   logic signed [18:0] doe5_ff;
   logic [7:0]         era5_ff;
   logic               leap5_ff;
   logic [3:0]         mc5_ff;
   logic [4:0]         day5_ff;
   logic signed [15:0] year5_ff;

   assign yoe_days = yoe4_ff * 9'd365;
   assign doe_in   = $signed({1'b0, yoe_days}) + 19'(extra4_ff);

   always_ff @(posedge clock) begin
      doe5_ff  <= doe_in;
      era5_ff  <= era4_ff;
      leap5_ff <= leap4_ff;
      mc5_ff   <= mc4_ff;
      day5_ff  <= day4_ff;
      year5_ff <= year4_ff;
   end

   // stage 6: days in whole eras
   logic [24:0]        era_days;
   logic [24:0]        era6_days_ff;
   logic signed [18:0] doe6_ff;
   logic               leap6_ff;
   logic [3:0]         mc6_ff;
   logic [4:0]         day6_ff;
   logic signed [15:0] year6_ff;

   assign era_days = era5_ff * ERA_DAYS;

   always_ff @(posedge clock) begin
      era6_days_ff <= era_days;
      doe6_ff      <= doe5_ff;
      leap6_ff     <= leap5_ff;
      mc6_ff       <= mc5_ff;
      day6_ff      <= day5_ff;
      year6_ff     <= year5_ff;
   end

   // stage 7: day count from the epoch, masked to 25 bits
   logic signed [26:0] dn_wide;
   cdc_date_type       date_in;
   cdc_date_type       date_ff;

   assign dn_wide = $signed({2'b00, era6_days_ff}) + 27'(doe6_ff) - DN_BIAS;

   always_comb begin
      date_in.year         = year6_ff;
      date_in.month        = mc6_ff;
      date_in.day          = day6_ff;
      date_in.day_number   = dn_wide[24:0];
      date_in.leap         = leap6_ff;
      date_in.out_of_range = 1'b0;
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
   end

   assign date = date_ff;

endmodule

// ----- hw/rtl/cdc_fin.sv -----
module cdc_fin (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid,
   input  logic                  operation,
   input  cdc_pkg::cdc_date_type d2c_date,
   input  cdc_pkg::cdc_date_type c2d_date,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_out_year,
   output logic [3:0]            rsp_out_month,
   output logic [4:0]            rsp_out_day,
   output logic [2:0]            rsp_out_weekday,
   output logic [4:0]            rsp_month_length,
   output logic signed [24:0]    rsp_out_day_number,
   output logic                  rsp_out_of_range
);
   import cdc_pkg::*;

   // days + 4 plus a multiple of 7 that keeps the sum positive
   localparam logic signed [26:0] WDAY_BIAS   = 27'sd29360132;
   localparam int                 WDAY_DIGITS = 9;

   // stage 1: pick the path, month length, octal digit sum for mod 7
   cdc_date_type       sel;
   logic [4:0]         len_in;
   logic signed [26:0] wx_wide;
   logic [26:0]        wx_pad;
   logic [5:0]         dsum_in;
   logic               valid1_ff;
   cdc_date_type       sel1_ff;
   logic [4:0]         len1_ff;
   logic [5:0]         dsum1_ff;

   assign sel = (operation == OP_DATE_TO_DAYS) ? c2d_date : d2c_date;

   always_comb begin
      if (sel.out_of_range) begin
         len_in = 5'd0;
      end else if (sel.month == 4'd2) begin
         len_in = sel.leap ? 5'd29 : 5'd28;
      end else begin
         len_in = {1'b0, sel.month ^ (sel.month >> 3)} | 5'd30;
      end
   end

   assign wx_wide = 27'(sel.day_number) + WDAY_BIAS;
   assign wx_pad  = {1'b0, wx_wide[25:0]};

   // 8 is 1 mod 7, so octal digits add up to the same residue
   always_comb begin
      dsum_in = 6'd0;
      for (int i = 0; i < WDAY_DIGITS; i++) begin
         dsum_in = dsum_in + 6'(wx_pad[3*i +: 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      sel1_ff  <= sel;
      len1_ff  <= len_in;
      dsum1_ff <= dsum_in;
   end

   // stage 2: fold the digit sum down to the weekday
   logic [3:0] fold2;
   logic [2:0] fold3;
   logic [2:0] wday_in;
   logic       valid2_ff;
   logic signed [15:0] year2_ff;
   logic [3:0]         month2_ff;
   logic [4:0]         day2_ff;
   logic [2:0]         wday2_ff;
   logic [4:0]         len2_ff;
   logic signed [24:0] dn2_ff;
   logic               oor2_ff;

   assign fold2   = 4'(dsum1_ff[5:3]) + 4'(dsum1_ff[2:0]);
   assign fold3   = 3'(fold2[3]) + fold2[2:0];
   assign wday_in = (fold3 == 3'd7) ? 3'd0 : fold3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      year2_ff  <= sel1_ff.year;
      month2_ff <= sel1_ff.month;
      day2_ff   <= sel1_ff.day;
      wday2_ff  <= wday_in;
      len2_ff   <= len1_ff;
      dn2_ff    <= sel1_ff.day_number;
      oor2_ff   <= sel1_ff.out_of_range;
   end

   assign rsp_valid          = valid2_ff;
   assign rsp_out_year       = year2_ff;
   assign rsp_out_month      = month2_ff;
   assign rsp_out_day        = day2_ff;
   assign rsp_out_weekday    = wday2_ff;
   assign rsp_month_length   = len2_ff;
   assign rsp_out_day_number = dn2_ff;
   assign rsp_out_of_range   = oor2_ff;

endmodule

// ----- hw/rtl/civil_date_converter.sv -----
// Proleptic Gregorian date converter, fully pipelined. One word is taken on
// every cycle that start is high; busy never rises. Each word comes back on the
// rsp_ ports, marked by rsp_valid for one cycle, in the order taken, after the
// 7 stages of the two conversion paths, which run side by side, and then the
// 2 stages that select the path and work out weekday and month length.
// The result cannot be held off, so the receiver must take every strobe.
// Operation 0 turns a day count from 1970-01-01 into a date and flags years
// outside the 16-bit range; operation 1 turns a year, month and day into the
// day count, with the month clamped to 1..12 and the day not checked.
module civil_date_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [24:0] req_in_day_number,
   input  logic signed [15:0] req_in_year,
   input  logic [3:0]         req_in_month,
   input  logic [4:0]         req_in_day,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_out_year,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic [2:0]         rsp_out_weekday,
   output logic [4:0]         rsp_month_length,
   output logic signed [24:0] rsp_out_day_number,
   output logic               rsp_out_of_range
);
   import cdc_pkg::*;

   // every stage advances each cycle
   assign busy = 1'b0;

   // valid and operation travel alongside the two paths
   logic [PATH_STAGES-1:0] valid_ff;
   logic [PATH_STAGES-1:0] op_ff;
   logic [PATH_STAGES-1:0] valid_in;
   logic [PATH_STAGES-1:0] op_in;

   assign valid_in = {valid_ff[PATH_STAGES-2:0], start & ~busy};
   assign op_in    = {op_ff[PATH_STAGES-2:0], req_operation};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   // day count to date
   cdc_date_type d2c_date;

   cdc_d2c u_d2c (
      .clock      (clock),
      .day_number (req_in_day_number),
      .date       (d2c_date)
   );

   // date to day count
   cdc_date_type c2d_date;

   cdc_c2d u_c2d (
      .clock (clock),
      .year  (req_in_year),
      .month (req_in_month),
      .day   (req_in_day),
      .date  (c2d_date)
   );

   // path select, weekday, month length, result register
   cdc_fin u_fin (
      .clock              (clock),
      .reset              (reset),
      .valid              (valid_ff[PATH_STAGES-1]),
      .operation          (op_ff[PATH_STAGES-1]),
      .d2c_date           (d2c_date),
      .c2d_date           (c2d_date),
      .rsp_valid          (rsp_valid),
      .rsp_out_year       (rsp_out_year),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_day        (rsp_out_day),
      .rsp_out_weekday    (rsp_out_weekday),
      .rsp_month_length   (rsp_month_length),
      .rsp_out_day_number (rsp_out_day_number),
      .rsp_out_of_range   (rsp_out_of_range)
   );

endmodule
